// ===== hw/rtl/ssc_pkg.sv =====
// ---------------------------------------------------------------------------
// Sphere contact package
// Shared widths and the request record that moves along the cell chains.
// ---------------------------------------------------------------------------
package ssc_pkg;

   localparam int MAG_W    = 31;  // separation magnitude once the far test passes
   localparam int RADIUS_W = 30;
   localparam int RSUM_W   = 31;
   localparam int DIST_W   = 32;
   localparam int SQ_W     = 64;  // sum of squares and square-root work registers
   localparam int SQRT_STEPS = 32;
   localparam int LIMIT_W  = 16;
   localparam int NORMAL_W = 16;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic                  far;
      logic [RADIUS_W-1:0]   r1;
      logic [RSUM_W-1:0]     rsum;
      logic [DIST_W-1:0]     sep_len;
      logic                  hit;
      logic                  near;
   } item_type;

endpackage

// ===== hw/rtl/ssc_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// Square-root cell
// One digit step of the integer square root; fixed trial bit per position.
// ---------------------------------------------------------------------------
module ssc_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                          clock,
   input  logic                          adv,
   input  ssc_pkg::item_type             item_i,
   input  logic [ssc_pkg::SQ_W-1:0]      s_i,
   input  logic [ssc_pkg::SQ_W-1:0]      r_i,
   output ssc_pkg::item_type             item_o,
   output logic [ssc_pkg::SQ_W-1:0]      s_o,
   output logic [ssc_pkg::SQ_W-1:0]      r_o
);
   localparam logic [ssc_pkg::SQ_W-1:0] TRIAL =
      ssc_pkg::SQ_W'(1) << (ssc_pkg::SQ_W - 2 - 2 * STEP);

   ssc_pkg::item_type          item_ff;
   logic [ssc_pkg::SQ_W-1:0]   s_ff, s_in, r_ff, r_in, t;

   always_comb begin
      t = r_i + TRIAL;
      if (s_i >= t) begin
         s_in = s_i - t;
         r_in = (r_i >> 1) + TRIAL;
      end else begin
         s_in = s_i;
         r_in = r_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_i;
         s_ff    <= s_in;
         r_ff    <= r_in;
      end
   end

   assign item_o = item_ff;
   assign s_o    = s_ff;
   assign r_o    = r_ff;
endmodule

// ===== hw/rtl/ssc_div_cell.sv =====
// ---------------------------------------------------------------------------
// Divide cell
// One restoring quotient bit for each of the three normal components.
// ---------------------------------------------------------------------------
module ssc_div_cell #(
   parameter int FRAC = 15,
   parameter int STEP = 15
) (
   input  logic                              clock,
   input  logic                              adv,
   input  ssc_pkg::item_type                 item_i,
   input  logic [2:0][ssc_pkg::DIST_W+FRAC-1:0] rem_i,
   input  logic [2:0][FRAC:0]                q_i,
   output ssc_pkg::item_type                 item_o,
   output logic [2:0][ssc_pkg::DIST_W+FRAC-1:0] rem_o,
   output logic [2:0][FRAC:0]                q_o
);
   localparam int NW = ssc_pkg::DIST_W + FRAC;

   ssc_pkg::item_type      item_ff;
   logic [2:0][NW-1:0]     rem_ff, rem_in;
   logic [2:0][FRAC:0]     q_ff, q_in;
   logic [NW-1:0]          dsh;

   always_comb begin
      dsh = NW'(item_i.sep_len) << STEP;
      for (int i = 0; i < 3; i++) begin
         rem_in[i] = rem_i[i];
         q_in[i]   = q_i[i];
         if (rem_i[i] >= dsh) begin
            rem_in[i]     = rem_i[i] - dsh;
            q_in[i][STEP] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_i;
         rem_ff  <= rem_in;
         q_ff    <= q_in;
      end
   end

   assign item_o = item_ff;
   assign rem_o  = rem_ff;
   assign q_o    = q_ff;
endmodule

// ===== hw/rtl/sphere_sphere_contact.sv =====
// ---------------------------------------------------------------------------
// Sphere-sphere contact detector
// Overlap test, contact normal, depth and contact point for sphere pairs.
// ---------------------------------------------------------------------------
// Fully pipelined: one request is taken every cycle unless the output stalls.
// The pipeline holds the chain of 32 square-root cells and the chain of
// NORMAL_FRAC_BITS + 1 divide cells; the remaining stages form the
// separation, the squares and their sum, the hit decision with the dividend
// set-up, the scaled radius and the final saturating add. When a result
// waits and rsp_ready is low, the whole pipeline holds and req_ready drops
// until the result is taken.
module sphere_sphere_contact #(
   parameter int COORD_WIDTH      = 32,
   parameter int NORMAL_FRAC_BITS = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [15:0]                csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_z,
   input  logic [29:0]                req_first_radius,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_z,
   input  logic [29:0]                req_second_radius,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_contact_x,
   output logic signed [COORD_WIDTH-1:0] rsp_contact_y,
   output logic signed [COORD_WIDTH-1:0] rsp_contact_z,
   output logic signed [15:0]         rsp_normal_x,
   output logic signed [15:0]         rsp_normal_y,
   output logic signed [15:0]         rsp_normal_z,
   output logic [30:0]                rsp_depth
);
   localparam int CW    = COORD_WIDTH;
   localparam int F     = NORMAL_FRAC_BITS;
   localparam int NW    = ssc_pkg::DIST_W + F;
   localparam int DW    = CW + 1;
   localparam int AW    = (DW > ssc_pkg::RSUM_W) ? DW : ssc_pkg::RSUM_W;
   localparam int PW    = F + ssc_pkg::RADIUS_W;
   localparam int SW    = ((CW > ssc_pkg::MAG_W) ? CW : ssc_pkg::MAG_W) + 1;
   localparam int NMW   = (F + 1 > ssc_pkg::NORMAL_W) ? F + 1 : ssc_pkg::NORMAL_W;
   localparam int NSQ   = ssc_pkg::SQRT_STEPS;
   localparam int DEPTH = 38 + F;  // stage registers ahead of the output
   localparam logic [F-1:0] NMAX = {F{1'b1}};

   logic adv;
   logic [DEPTH-1:0] vld_ff;
   logic [CW-1:0] c1_ff [DEPTH][3];
   logic [ssc_pkg::LIMIT_W-1:0] limit_ff;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ssc_pkg::LIMIT_W'(1);
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff[0][0] <= req_first_x;
         c1_ff[0][1] <= req_first_y;
         c1_ff[0][2] <= req_first_z;
         for (int k = 1; k < DEPTH; k++) begin
            c1_ff[k] <= c1_ff[k-1];
         end
      end
   end

   // Front stage: separation, magnitudes and the per-axis far test.
   logic signed [DW-1:0] first_c [3], second_c [3], diff [3];
   logic [DW-1:0] mag_full [3];
   ssc_pkg::item_type front_in, front_ff;

   always_comb begin
      first_c[0]  = DW'(req_first_x);
      first_c[1]  = DW'(req_first_y);
      first_c[2]  = DW'(req_first_z);
      second_c[0] = DW'(req_second_x);
      second_c[1] = DW'(req_second_y);
      second_c[2] = DW'(req_second_z);
      front_in      = '0;
      front_in.r1   = req_first_radius;
      front_in.rsum = ssc_pkg::RSUM_W'(req_first_radius) + ssc_pkg::RSUM_W'(req_second_radius);
      for (int i = 0; i < 3; i++) begin
         diff[i]     = second_c[i] - first_c[i];
         mag_full[i] = diff[i][DW-1] ? DW'(-diff[i]) : DW'(diff[i]);
         front_in.neg[i] = diff[i][DW-1];
         front_in.mag[i] = ssc_pkg::MAG_W'(mag_full[i]);
         if (AW'(mag_full[i]) >= AW'(front_in.rsum)) begin
            front_in.far = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         front_ff <= front_in;
      end
   end

   // Squares, then their sum.
   ssc_pkg::item_type sq_item_ff, sum_item_ff;
   logic [2*ssc_pkg::MAG_W-1:0] sq_ff [3];
   logic [ssc_pkg::SQ_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_item_ff  <= front_ff;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= front_ff.mag[i] * front_ff.mag[i];
         end
         sum_item_ff <= sq_item_ff;
         sum_ff      <= ssc_pkg::SQ_W'(sq_ff[0]) + ssc_pkg::SQ_W'(sq_ff[1])
                      + ssc_pkg::SQ_W'(sq_ff[2]);
      end
   end

   // Square-root chain.
   ssc_pkg::item_type sr_item [NSQ+1];
   logic [ssc_pkg::SQ_W-1:0] sr_s [NSQ+1];
   logic [ssc_pkg::SQ_W-1:0] sr_r [NSQ+1];

   assign sr_item[0] = sum_item_ff;
   assign sr_s[0]    = sum_ff;
   assign sr_r[0]    = '0;

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      ssc_sqrt_cell #(.STEP(k)) u_cell (
         .clock  (clock),
         .adv    (adv),
         .item_i (sr_item[k]),
         .s_i    (sr_s[k]),
         .r_i    (sr_r[k]),
         .item_o (sr_item[k+1]),
         .s_o    (sr_s[k+1]),
         .r_o    (sr_r[k+1])
      );
   end

   // Hit and coincidence decisions, dividend set-up.
   ssc_pkg::item_type prep_in, prep_ff;
   logic [2:0][NW-1:0] prep_rem_in, prep_rem_ff;

   always_comb begin
      prep_in         = sr_item[NSQ];
      prep_in.sep_len = sr_r[NSQ][ssc_pkg::DIST_W-1:0];
      prep_in.hit     = !prep_in.far
                      && (prep_in.sep_len < ssc_pkg::DIST_W'(prep_in.rsum));
      prep_in.near    = prep_in.sep_len <= ssc_pkg::DIST_W'(limit_ff);
      for (int i = 0; i < 3; i++) begin
         prep_rem_in[i] = (NW'(prep_in.mag[i]) << F) + NW'(prep_in.sep_len >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prep_ff     <= prep_in;
         prep_rem_ff <= prep_rem_in;
      end
   end

   // Divide chain, most significant quotient bit first.
   ssc_pkg::item_type dv_item [F+2];
   logic [2:0][NW-1:0] dv_rem [F+2];
   logic [2:0][F:0]    dv_q   [F+2];

   assign dv_item[0] = prep_ff;
   assign dv_rem[0]  = prep_rem_ff;
   assign dv_q[0]    = '0;

   for (genvar k = 0; k <= F; k++) begin : g_div
      ssc_div_cell #(.FRAC(F), .STEP(F - k)) u_cell (
         .clock  (clock),
         .adv    (adv),
         .item_i (dv_item[k]),
         .rem_i  (dv_rem[k]),
         .q_i    (dv_q[k]),
         .item_o (dv_item[k+1]),
         .rem_o  (dv_rem[k+1]),
         .q_o    (dv_q[k+1])
      );
   end

   // Clamp the normal and scale the first radius by it.
   ssc_pkg::item_type mul_item_ff, dv_last;
   logic [F-1:0]  nm_in [3];
   logic [F-1:0]  nm_ff [3];
   logic [2:0]    sgn_in, sgn_ff;
   logic [PW-1:0] prod_ff [3];

   always_comb begin
      dv_last = dv_item[F+1];
      for (int i = 0; i < 3; i++) begin
         if (dv_last.near) begin
            nm_in[i]  = (i == 0) ? NMAX : '0;
            sgn_in[i] = 1'b0;
         end else begin
            nm_in[i]  = (dv_q[F+1][i] > (F+1)'(NMAX)) ? NMAX : dv_q[F+1][i][F-1:0];
            sgn_in[i] = dv_last.neg[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_item_ff <= dv_last;
         sgn_ff      <= sgn_in;
         for (int i = 0; i < 3; i++) begin
            nm_ff[i]   <= nm_in[i];
            prod_ff[i] <= PW'(nm_in[i]) * PW'(dv_last.r1);
         end
      end
   end

   // Output stage: rounded offset, saturating add, zeroed on a miss.
   logic [PW:0]            off_wide [3];
   logic [ssc_pkg::MAG_W-1:0] off [3];
   logic signed [SW-1:0]   csum [3];
   logic [CW-1:0]          cpt [3];
   logic [NMW-1:0]         nrm [3];
   logic                   hit_ff;
   logic [CW-1:0]          cpt_ff [3];
   logic [15:0]            nrm_ff [3];
   logic [30:0]            depth_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         off_wide[i] = (PW+1)'(prod_ff[i]) + ((PW+1)'(1) << (F - 1));
         off[i]      = off_wide[i][F +: ssc_pkg::MAG_W];
         csum[i]     = {{(SW-CW){c1_ff[DEPTH-1][i][CW-1]}}, c1_ff[DEPTH-1][i]};
         if (sgn_ff[i]) begin
            csum[i] = csum[i] - SW'(off[i]);
            nrm[i]  = NMW'(-NMW'(nm_ff[i]));
         end else begin
            csum[i] = csum[i] + SW'(off[i]);
            nrm[i]  = NMW'(nm_ff[i]);
         end
         if (csum[i][SW-1:CW-1] == '0 || csum[i][SW-1:CW-1] == '1) begin
            cpt[i] = csum[i][CW-1:0];
         end else if (csum[i][SW-1]) begin
            cpt[i] = {1'b1, {(CW-1){1'b0}}};
         end else begin
            cpt[i] = {1'b0, {(CW-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (adv) begin
         rsp_valid <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff   <= mul_item_ff.hit;
         depth_ff <= mul_item_ff.hit
                   ? 31'(mul_item_ff.rsum - ssc_pkg::RSUM_W'(mul_item_ff.sep_len)) : '0;
         for (int i = 0; i < 3; i++) begin
            cpt_ff[i] <= mul_item_ff.hit ? cpt[i] : '0;
            nrm_ff[i] <= mul_item_ff.hit ? nrm[i][15:0] : '0;
         end
      end
   end

   assign rsp_hit       = hit_ff;
   assign rsp_contact_x = cpt_ff[0];
   assign rsp_contact_y = cpt_ff[1];
   assign rsp_contact_z = cpt_ff[2];
   assign rsp_normal_x  = nrm_ff[0];
   assign rsp_normal_y  = nrm_ff[1];
   assign rsp_normal_z  = nrm_ff[2];
   assign rsp_depth     = depth_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_depth == '0 && rsp_contact_x == '0
         && rsp_contact_y == '0 && rsp_contact_z == '0 && rsp_normal_x == '0
         && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("miss result carries nonzero fields");

   a_hit_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_depth != '0)
      else $error("hit reported with zero depth");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && vld_ff == '0)
      else $error("pipeline not empty after reset");
endmodule

// ===== tb/sv/sphere_sphere_contact_test.sv =====
// ---------------------------------------------------------------------------
// Sphere-sphere contact detector testbench
// Drives sphere pairs through the request channel under random idling and a
// long output hold-off, predicts each contact result in the testbench and
// compares every response field against the oldest pending prediction.
// ---------------------------------------------------------------------------
module sphere_sphere_contact_test;

   localparam int CW = 32;
   localparam int NF = 15;
   localparam int LATENCY = 38 + NF;

   typedef struct packed {
      logic signed [CW-1:0] x1, y1, z1;
      logic [29:0]          r1;
      logic signed [CW-1:0] x2, y2, z2;
      logic [29:0]          r2;
   } pair_type;

   typedef struct packed {
      logic                 hit;
      logic signed [CW-1:0] cx, cy, cz;
      logic signed [15:0]   nx, ny, nz;
      logic [30:0]          depth;
   } contact_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [15:0] csr_wr_data = 0;
   logic req_valid = 0;
   logic req_ready;
   pair_type req = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   contact_type rsp;

   logic [15:0] near_limit;
   contact_type pending_contacts[$];
   int mismatches = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int hits_seen = 0;
   int hold_cycles = 0;

   sphere_sphere_contact #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(NF)) dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_first_x(req.x1), .req_first_y(req.y1), .req_first_z(req.z1),
      .req_first_radius(req.r1),
      .req_second_x(req.x2), .req_second_y(req.y2), .req_second_z(req.z2),
      .req_second_radius(req.r2),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit(rsp.hit),
      .rsp_contact_x(rsp.cx), .rsp_contact_y(rsp.cy), .rsp_contact_z(rsp.cz),
      .rsp_normal_x(rsp.nx), .rsp_normal_y(rsp.ny), .rsp_normal_z(rsp.nz),
      .rsp_depth(rsp.depth)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] s);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [CW-1:0] clamp_coord(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi[CW-1:0];
      if (v < lo) return lo[CW-1:0];
      return v[CW-1:0];
   endfunction

   function automatic contact_type predict_contact(pair_type p);
      contact_type c;
      longint c1[3], d[3], n, off;
      logic [63:0] a[3], rsum, s, sep_len, nm, one;
      logic far;
      c = '0;
      one = 64'd1 << NF;
      rsum = 64'(p.r1) + 64'(p.r2);
      c1[0] = p.x1; c1[1] = p.y1; c1[2] = p.z1;
      d[0] = longint'(p.x2) - c1[0];
      d[1] = longint'(p.y2) - c1[1];
      d[2] = longint'(p.z2) - c1[2];
      far = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = d[i] < 0 ? -d[i] : d[i];
         if (a[i] >= rsum) far = 1;
      end
      if (far) return c;
      for (int i = 0; i < 3; i++) s += a[i] * a[i];
      sep_len = int_sqrt(s);
      if (sep_len >= rsum) return c;
      c.hit = 1;
      for (int i = 0; i < 3; i++) begin
         if (sep_len <= 64'(near_limit)) begin
            nm = (i == 0) ? one - 1 : 0;
            n = nm;
         end else begin
            nm = (a[i] * one + sep_len / 2) / sep_len;
            if (nm > one - 1) nm = one - 1;
            n = d[i] < 0 ? -longint'(nm) : longint'(nm);
         end
         off = longint'((nm * 64'(p.r1) + (one >> 1)) >> NF);
         if (n < 0) off = -off;
         case (i)
            0: begin c.cx = clamp_coord(c1[i] + off); c.nx = n[15:0]; end
            1: begin c.cy = clamp_coord(c1[i] + off); c.ny = n[15:0]; end
            default: begin c.cz = clamp_coord(c1[i] + off); c.nz = n[15:0]; end
         endcase
      end
      c.depth = 31'(rsum - sep_len);
      return c;
   endfunction

   // Response checker and receiver idling.
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         contact_type want;
         responses_seen++;
         if (rsp.hit) hits_seen++;
         if (pending_contacts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp);
         end else begin
            want = pending_contacts.pop_front();
            if (want !== rsp) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", want, rsp);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
         if (rsp_valid && rsp_ready) rsp_gap = ($urandom_range(3) == 0) ? 0 :
            ($urandom_range(1) ? $urandom_range(11) : 0);
      end
   end

   // The request stays valid after acceptance until the next call or a drain
   // lowers it at the same falling edge, so each edge sees one assignment.
   task automatic send_pair(pair_type p, bit idle);
      int gap;
      gap = idle ? ($urandom_range(1) ? $urandom_range(11) : 0) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req <= p;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_contacts.push_back(predict_contact(p));
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending_contacts.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_limit(logic [15:0] v);
      drain();
      @(negedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 0;
      near_limit = v;
   endtask

   function automatic pair_type make_pair(logic signed [CW-1:0] x1, y1, z1,
      int r1, logic signed [CW-1:0] x2, y2, z2, int r2);
      pair_type p;
      p.x1 = x1; p.y1 = y1; p.z1 = z1; p.r1 = 30'(r1);
      p.x2 = x2; p.y2 = y2; p.z2 = z2; p.r2 = 30'(r2);
      return p;
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      logic [29:0] span;
      int shift;
      p = $bits(pair_type)'({$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(9) != 0) begin
         // Mostly nearby spheres so that the overlap path is well exercised.
         shift = $urandom_range(29, 4);
         span = 30'((64'd1 << shift) - 1);
         p.r1 = 30'($urandom) & span;
         p.r2 = 30'($urandom) & span;
         p.x2 = p.x1 + $signed(($urandom & span) - (span >> 1));
         p.y2 = p.y1 + $signed(($urandom & span) - (span >> 1));
         p.z2 = p.z1 + $signed(($urandom & span) - (span >> 1));
         if ($urandom_range(7) == 0) begin
            p.x2 = p.x1 + $signed($urandom_range(3) - 1);
            p.y2 = p.y1;
            p.z2 = p.z1 + $signed($urandom_range(2) - 1);
         end
      end
      return p;
   endfunction

   task automatic test_directed;
      logic signed [CW-1:0] mx, mn;
      logic [29:0] rmax;
      mx = {1'b0, {(CW-1){1'b1}}};
      mn = {1'b1, {(CW-1){1'b0}}};
      rmax = '1;
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 0);
      send_pair(make_pair(0, 0, 0, 1, 0, 0, 0, 0), 0);
      send_pair(make_pair(5, 5, 5, rmax, 5, 5, 5, rmax), 0);
      send_pair(make_pair(0, 0, 0, 100, 1, 0, 0, 100), 0);
      send_pair(make_pair(mx, mx, mx, rmax, mx, mx, mx - 2, rmax), 0);
      send_pair(make_pair(mn, mn, mn, rmax, mn + 3, mn, mn, rmax), 0);
      send_pair(make_pair(mx - 100, 0, 0, rmax, mx, 0, 0, rmax), 0);
      send_pair(make_pair(mn + 100, 0, 0, rmax, mn, 0, 0, rmax), 0);
      send_pair(make_pair(0, 0, 0, 65536, 65536, 0, 0, 0), 0);
      send_pair(make_pair(0, 0, 0, 65536, 65535, 0, 0, 0), 0);
      send_pair(make_pair(0, 0, 0, 65536, 0, -40000, 0, 0), 0);
      send_pair(make_pair(0, 0, 0, 65536, 0, 0, 40000, 0), 0);
      send_pair(make_pair(0, 0, 0, 70000, 40000, 40000, 40000, 0), 0);
      send_pair(make_pair(mn, 0, 0, rmax, mx, 0, 0, rmax), 0);
      send_pair(make_pair(10, -20, 30, 1000, -500, 700, -300, 1000), 0);
      send_pair(make_pair(0, 0, 0, rmax, -1000000, 2000000, -3000000, rmax), 0);
   endtask

   task automatic test_limit_settings;
      logic [15:0] limits[4] = '{16'hFFFF, 16'd0, 16'd300, 16'd1};
      foreach (limits[k]) begin
         write_limit(limits[k]);
         send_pair(make_pair(0, 0, 0, 100000, 0, 0, 0, 5), 0);
         send_pair(make_pair(0, 0, 0, 100000, 1, 0, 0, 5), 0);
         send_pair(make_pair(0, 0, 0, 100000, 300, -1, 0, 5), 0);
         send_pair(make_pair(0, 0, 0, 100000, 0, 301, 0, 5), 0);
         send_pair(make_pair(0, 0, 0, 100000, 0, -40000, 30000, 5), 0);
         for (int i = 0; i < 150; i++) send_pair(random_pair(), 1);
      end
   endtask

   task automatic test_backpressure;
      drain();
      hold_cycles = 400;
      for (int i = 0; i < 150; i++) send_pair(random_pair(), 0);
   endtask

   task automatic test_random_stream;
      write_limit(16'($urandom));
      for (int i = 0; i < 200; i++) send_pair(random_pair(), 1);
      write_limit(16'd1);
      for (int i = 0; i < 100; i++) send_pair(random_pair(), 0);
   endtask

   initial begin
      near_limit = 16'd1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_limit_settings();
      test_backpressure();
      test_random_stream();
      drain();
      $display("Sent %0d sphere pairs, checked %0d responses, %0d of them hits.",
               requests_sent, responses_seen, hits_seen);
      $display("Covered coincidence limits 0, 1, 300, max and random, plus a long output stall.");
      if (mismatches == 0 && pending_contacts.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
